>>> rtl/iftrc_pkg.sv
// shared types and constants of the ipv4 flow tuple redirect classifier
`default_nettype none

package iftrc_pkg;

    localparam int FLOW_ENTRIES = 16;
    localparam int QUEUE_COUNT  = 64;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;

    // byte offsets in the frame
    localparam logic [7:0] POS_ETYPE_HI   = 8'd12;
    localparam logic [7:0] POS_ETYPE_LO   = 8'd13;
    localparam logic [7:0] POS_IHL        = 8'd14;
    localparam logic [7:0] POS_PROTO      = 8'd23;
    localparam logic [7:0] POS_ADDR_FIRST = 8'd26;
    localparam logic [7:0] POS_ADDR_END   = 8'd34;

    localparam logic [8:0]  ETH_HDR_LEN  = 9'd14;
    localparam logic [8:0]  IP_MIN_END   = 9'd34;
    localparam logic [15:0] ETYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  IHL_MASK     = 8'h0f;
    localparam logic [5:0]  MIN_HDR_LEN  = 6'd20;
    localparam logic [8:0]  TCP_HDR_LEN  = 9'd20;
    localparam logic [8:0]  UDP_HDR_LEN  = 9'd8;
    localparam logic [7:0]  COUNT_MAX    = 8'd255;

    typedef enum logic [1:0] {
        CMD_BYTE       = 2'd0,
        CMD_FLOW_WRITE = 2'd1,
        CMD_SOCKET_SET = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        REASON_MATCH     = 3'd0,
        REASON_SHORT     = 3'd1,
        REASON_NOT_IP    = 3'd2,
        REASON_BAD_IHL   = 3'd3,
        REASON_NOT_L4    = 3'd4,
        REASON_NO_FLOW   = 3'd5,
        REASON_NO_SOCKET = 3'd6
    } reason_t;

    typedef enum logic {
        VERDICT_PASS     = 1'b0,
        VERDICT_REDIRECT = 1'b1
    } verdict_t;

    // one flow table write
    typedef struct packed {
        logic        en;
        logic [3:0]  index;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic        valid;
    } flow_wr_t;

endpackage

`default_nettype wire

>>> rtl/iftrc_flow_table.sv
// flow table storage with parallel exact match of the 4-tuple
`default_nettype none

module iftrc_flow_table
    import iftrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire flow_wr_t    wr,
    input  wire logic [63:0] key_addrs,
    input  wire logic [31:0] key_ports,
    output logic             hit
);

    logic [63:0] addrs_reg [FLOW_ENTRIES];
    logic [31:0] ports_reg [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < FLOW_ENTRIES; i++) begin
                if (wr.en && int'(wr.index) == i) begin
                    valid_reg[i] <= wr.valid;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < FLOW_ENTRIES; i++) begin
            if (wr.en && int'(wr.index) == i) begin
                addrs_reg[i] <= wr.addrs;
                ports_reg[i] <= wr.ports;
            end
        end
    end

    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < FLOW_ENTRIES; i++) begin
            if (valid_reg[i] && addrs_reg[i] == key_addrs && ports_reg[i] == key_ports) begin
                hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/ipv4_flow_tuple_redirect_classifier.sv
// top level: byte-wise ipv4 parser with 4-tuple flow redirect verdict
//
// channel  dir  tdata bits  tuser  tlast  carries
// s_axis   in   120         cmd    last   frame bytes, flow writes, socket bindings
// m_axis   out  16          -      -      one verdict per frame
//
// one beat per cycle sustained while no verdict stalls; a beat is parsed in the
// input register and its verdict appears on m_axis the cycle after it leaves it.
// the per-cycle path is the byte decode plus the 16-entry parallel tuple compare.
// reset clears the frame state, all flow valid bits and all socket bindings.
// a stalled verdict holds only last beats; other beats keep flowing.
`default_nettype none

module ipv4_flow_tuple_redirect_classifier
    import iftrc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // data_byte[7:0] rx_queue[13:8] entry_index[17:14] entry_remote_addr[49:18]
    // entry_remote_port[65:50] entry_local_addr[97:66] entry_local_port[113:98]
    // entry_valid[114] zero[119:115]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    // cmd[1:0]
    input  wire logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // verdict[0] target_queue[6:1] pass_reason[9:7] zero[15:10]
    output logic [M_TDATA_W-1:0]      m_axis_tdata
);

    // input register
    logic                 in_valid_reg;
    logic [1:0]           in_cmd_reg;
    logic                 in_last_reg;
    logic [S_TDATA_W-1:0] in_data_reg;

    // frame state
    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [5:0]  hdr_len_reg,     hdr_len_next;
    reason_t     parse_status_reg, parse_status_next;
    logic        is_tcp_reg,      is_tcp_next;
    logic [63:0] frame_words_reg, frame_words_next;
    logic [31:0] frame_ports_reg, frame_ports_next;

    logic [QUEUE_COUNT-1:0] socket_bound_reg;

    // result register
    logic        out_valid_reg;
    verdict_t    verdict_reg;
    logic [5:0]  queue_reg;
    reason_t     reason_reg;

    cmd_t        cmd;
    logic        is_byte;
    logic        need_out;
    logic        advance;
    logic [7:0]  b;
    logic [5:0]  rx_queue;
    logic [7:0]  pos;
    logic [7:0]  l4_start;
    logic [8:0]  frame_len;
    logic [8:0]  l4_end;
    logic        bound;
    logic        hit;
    reason_t     reason;
    flow_wr_t    flow_wr;

    assign cmd      = cmd_t'(in_cmd_reg);
    assign b        = in_data_reg[7:0];
    assign rx_queue = in_data_reg[13:8];
    assign pos      = byte_count_reg;

    assign is_byte  = in_valid_reg && cmd == CMD_BYTE;
    assign need_out = is_byte && in_last_reg;
    assign advance  = in_valid_reg && (!need_out || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign flow_wr.en    = advance && cmd == CMD_FLOW_WRITE;
    assign flow_wr.index = in_data_reg[17:14];
    assign flow_wr.addrs = {in_data_reg[49:18], in_data_reg[97:66]};
    assign flow_wr.ports = {in_data_reg[65:50], in_data_reg[113:98]};
    assign flow_wr.valid = in_data_reg[114];

    iftrc_flow_table u_flow_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr        (flow_wr),
        .key_addrs (frame_words_next),
        .key_ports (frame_ports_next),
        .hit       (hit)
    );

    // header field capture for the byte at pos
    always_comb begin
        frame_words_next  = frame_words_reg;
        frame_ports_next  = frame_ports_reg;
        hdr_len_next      = hdr_len_reg;
        parse_status_next = parse_status_reg;
        is_tcp_next       = is_tcp_reg;
        unique case (pos)
            POS_ETYPE_HI: begin
                frame_words_next = {56'd0, b};
            end
            POS_ETYPE_LO: begin
                if ({frame_words_reg[7:0], b} != ETYPE_IPV4 && parse_status_reg == REASON_MATCH) begin
                    parse_status_next = REASON_NOT_IP;
                end
            end
            POS_IHL: begin
                hdr_len_next = {b[3:0] & IHL_MASK[3:0], 2'b00};
                if (hdr_len_next < MIN_HDR_LEN && parse_status_reg == REASON_MATCH) begin
                    parse_status_next = REASON_BAD_IHL;
                end
            end
            POS_PROTO: begin
                is_tcp_next = (b == PROTO_TCP);
                if (b != PROTO_TCP && b != PROTO_UDP && parse_status_reg == REASON_MATCH) begin
                    parse_status_next = REASON_NOT_L4;
                end
            end
            default: begin
            end
        endcase
        if (pos >= POS_ADDR_FIRST && pos < POS_ADDR_END) begin
            frame_words_next = {frame_words_next[55:0], b};
        end
        // ports start right after the ip header; hdr_len only changes at a low offset
        l4_start = 8'(ETH_HDR_LEN) + {2'b00, hdr_len_reg};
        if (hdr_len_reg >= MIN_HDR_LEN && pos >= l4_start && pos < l4_start + 8'd4) begin
            frame_ports_next = {frame_ports_reg[23:0], b};
        end
        byte_count_next = (byte_count_reg < COUNT_MAX) ? byte_count_reg + 8'd1 : byte_count_reg;
    end

    always_comb begin
        bound = 1'b0;
        for (int i = 0; i < QUEUE_COUNT; i++) begin
            if (int'(rx_queue) == i && socket_bound_reg[i]) begin
                bound = 1'b1;
            end
        end
    end

    // verdict reason in check order
    always_comb begin
        frame_len = {1'b0, pos} + 9'd1;
        l4_end    = ETH_HDR_LEN + {3'b000, hdr_len_next} + (is_tcp_next ? TCP_HDR_LEN : UDP_HDR_LEN);
        if (frame_len < ETH_HDR_LEN) begin
            reason = REASON_SHORT;
        end else if (parse_status_next == REASON_NOT_IP) begin
            reason = REASON_NOT_IP;
        end else if (frame_len < IP_MIN_END) begin
            reason = REASON_SHORT;
        end else if (parse_status_next != REASON_MATCH) begin
            reason = parse_status_next;
        end else if (frame_len < l4_end) begin
            reason = REASON_SHORT;
        end else if (!hit) begin
            reason = REASON_NO_FLOW;
        end else if (!bound) begin
            reason = REASON_NO_SOCKET;
        end else begin
            reason = REASON_MATCH;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg  <= s_axis_tuser;
            in_last_reg <= s_axis_tlast;
            in_data_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            hdr_len_reg      <= '0;
            parse_status_reg <= REASON_MATCH;
            is_tcp_reg       <= 1'b0;
            frame_words_reg  <= '0;
            frame_ports_reg  <= '0;
        end else if (advance && is_byte) begin
            if (in_last_reg) begin
                byte_count_reg   <= '0;
                hdr_len_reg      <= '0;
                parse_status_reg <= REASON_MATCH;
                is_tcp_reg       <= 1'b0;
                frame_words_reg  <= '0;
                frame_ports_reg  <= '0;
            end else begin
                byte_count_reg   <= byte_count_next;
                hdr_len_reg      <= hdr_len_next;
                parse_status_reg <= parse_status_next;
                is_tcp_reg       <= is_tcp_next;
                frame_words_reg  <= frame_words_next;
                frame_ports_reg  <= frame_ports_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            socket_bound_reg <= '0;
        end else if (advance && cmd == CMD_SOCKET_SET) begin
            for (int i = 0; i < QUEUE_COUNT; i++) begin
                if (int'(rx_queue) == i) begin
                    socket_bound_reg[i] <= in_data_reg[114];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && need_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && need_out) begin
            verdict_reg <= (reason == REASON_MATCH) ? VERDICT_REDIRECT : VERDICT_PASS;
            queue_reg   <= rx_queue;
            reason_reg  <= reason;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, reason_reg, queue_reg, verdict_reg};

    // a last byte that leaves the input register always shows up as a verdict
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && need_out) |=> m_axis_tvalid)
        else $error("verdict beat missing after last frame byte");

    // frame state is back to its start after a last byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && need_out) |=> (byte_count_reg == 8'd0 && parse_status_reg == REASON_MATCH))
        else $error("frame state not cleared after last byte");

    // reset empties both the input and the result register
    assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !m_axis_tvalid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

>>> sim/tb.sv
// testbench for the ipv4 flow tuple redirect classifier: frames and table commands in, verdicts checked
`timescale 1ns / 100ps

module tb;
    import iftrc_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int ITEM_TARGET   = 1650;
    localparam int FRAME_TARGET  = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        verdict_t    verdict;
        logic [5:0]  queue;
        reason_t     reason;
    } verdict_rec_t;

    // tracks flow table, socket bindings and frame parse state; predicts one verdict per frame
    class verdict_scoreboard;
        logic [63:0]  flow_addrs [FLOW_ENTRIES];
        logic [31:0]  flow_ports [FLOW_ENTRIES];
        logic         flow_live  [FLOW_ENTRIES];
        logic         sock_bound [QUEUE_COUNT];
        logic [7:0]   byte_pos;
        logic [5:0]   hdr_len;
        reason_t      parse_fault;
        logic         is_tcp;
        logic [63:0]  addr_word;
        logic [31:0]  port_word;
        verdict_rec_t verdict_q [$];
        int           errors;

        function new();
            foreach (flow_live[i]) begin
                flow_live[i]  = 1'b0;
                flow_addrs[i] = '0;
                flow_ports[i] = '0;
            end
            foreach (sock_bound[i]) sock_bound[i] = 1'b0;
            clear_frame();
            errors = 0;
        endfunction

        function void clear_frame();
            byte_pos    = '0;
            hdr_len     = '0;
            parse_fault = REASON_MATCH;
            is_tcp      = 1'b0;
            addr_word   = '0;
            port_word   = '0;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function void note_beat(logic [1:0] cmd, logic [S_TDATA_W-1:0] data, logic last);
            logic [7:0]   b;
            logic [5:0]   queue;
            int           pos;
            int           l4;
            int           len;
            int           need;
            logic         hit;
            verdict_rec_t rec;
            b     = data[7:0];
            queue = data[13:8];
            case (cmd)
                CMD_FLOW_WRITE: begin
                    flow_addrs[data[17:14]] = {data[49:18], data[97:66]};
                    flow_ports[data[17:14]] = {data[65:50], data[113:98]};
                    flow_live[data[17:14]]  = data[114];
                end
                CMD_SOCKET_SET: sock_bound[queue] = data[114];
                CMD_BYTE: begin
                    pos = byte_pos;
                    if (pos == POS_ETYPE_HI) begin
                        addr_word = {56'd0, b};
                    end else if (pos == POS_ETYPE_LO) begin
                        if ({addr_word[7:0], b} != ETYPE_IPV4 && parse_fault == REASON_MATCH)
                            parse_fault = REASON_NOT_IP;
                    end else if (pos == POS_IHL) begin
                        hdr_len = {b[3:0], 2'b00};
                        if (hdr_len < MIN_HDR_LEN && parse_fault == REASON_MATCH)
                            parse_fault = REASON_BAD_IHL;
                    end else if (pos == POS_PROTO) begin
                        is_tcp = (b == PROTO_TCP);
                        if (b != PROTO_TCP && b != PROTO_UDP && parse_fault == REASON_MATCH)
                            parse_fault = REASON_NOT_L4;
                    end
                    // the ethertype byte shifts out once all eight address bytes are in
                    if (pos >= POS_ADDR_FIRST && pos < POS_ADDR_END)
                        addr_word = {addr_word[55:0], b};
                    if (hdr_len >= MIN_HDR_LEN) begin
                        l4 = ETH_HDR_LEN + hdr_len;
                        if (pos >= l4 && pos < l4 + 4)
                            port_word = {port_word[23:0], b};
                    end
                    if (byte_pos != COUNT_MAX)
                        byte_pos = byte_pos + 8'd1;
                    if (last) begin
                        len  = pos + 1;
                        need = ETH_HDR_LEN + hdr_len + (is_tcp ? TCP_HDR_LEN : UDP_HDR_LEN);
                        hit  = 1'b0;
                        foreach (flow_live[i]) begin
                            if (flow_live[i] && flow_addrs[i] == addr_word
                                    && flow_ports[i] == port_word)
                                hit = 1'b1;
                        end
                        if (len < ETH_HDR_LEN)
                            rec.reason = REASON_SHORT;
                        else if (parse_fault == REASON_NOT_IP)
                            rec.reason = REASON_NOT_IP;
                        else if (len < IP_MIN_END)
                            rec.reason = REASON_SHORT;
                        else if (parse_fault != REASON_MATCH)
                            rec.reason = parse_fault;
                        else if (len < need)
                            rec.reason = REASON_SHORT;
                        else if (!hit)
                            rec.reason = REASON_NO_FLOW;
                        else if (!sock_bound[queue])
                            rec.reason = REASON_NO_SOCKET;
                        else
                            rec.reason = REASON_MATCH;
                        rec.verdict = (rec.reason == REASON_MATCH) ? VERDICT_REDIRECT
                                                                   : VERDICT_PASS;
                        rec.queue   = queue;
                        verdict_q.push_back(rec);
                        clear_frame();
                    end
                end
                default: ;  // reserved command is dropped
            endcase
        endfunction

        function void check_verdict(logic [M_TDATA_W-1:0] data);
            verdict_rec_t want;
            if (verdict_q.size() == 0) begin
                $error("verdict beat %h with no frame waiting for one", data);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (data[0] !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, data[0]);
                    errors++;
                end
                if (data[6:1] !== want.queue) begin
                    $error("target_queue: expected %0d, got %0d", want.queue, data[6:1]);
                    errors++;
                end
                if (data[9:7] !== want.reason) begin
                    $error("pass_reason: expected %0d, got %0d", want.reason, data[9:7]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic                 s_axis_tlast;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    verdict_scoreboard sb = new();

    // what the stimulus believes is in the table, used to aim frames at live flows
    logic [63:0] tbl_addrs [FLOW_ENTRIES];
    logic [31:0] tbl_ports [FLOW_ENTRIES];
    logic        tbl_live  [FLOW_ENTRIES];

    int   beats_sent  = 0;
    int   frames_sent = 0;
    int   cycle_count = 0;
    logic calm        = 1'b0;
    logic hold_armed  = 1'b0;
    logic hold_done   = 1'b0;

    ipv4_flow_tuple_redirect_classifier uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("ipv4_flow_tuple_redirect_classifier test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_beat(s_axis_tuser, s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_verdict(m_axis_tdata);
        end
    end

    // verdict side: random stalls, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_armed && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_axis_tready <= calm || ($urandom_range(0, 99) >= 7);
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_fields(logic [7:0] b, logic [5:0] queue,
            logic [3:0] idx, logic [31:0] raddr, logic [15:0] rport, logic [31:0] laddr,
            logic [15:0] lport, logic valid);
        return {5'd0, valid, lport, laddr, rport, raddr, idx, queue, b};
    endfunction

    function automatic logic [S_TDATA_W-1:0] noisy_fields(logic [7:0] b, logic [5:0] queue);
        return pack_fields(b, queue, 4'($urandom), $urandom, 16'($urandom), $urandom,
                           16'($urandom), 1'($urandom));
    endfunction

    function automatic byte_q_t build_frame(logic [15:0] etype, logic [7:0] ver_ihl,
            logic [7:0] proto, logic [63:0] addrs, logic [31:0] ports, int payload);
        byte_q_t q;
        repeat (12) q.push_back(8'($urandom));
        q.push_back(etype[15:8]);
        q.push_back(etype[7:0]);
        q.push_back(ver_ihl);
        repeat (8) q.push_back(8'($urandom));
        q.push_back(proto);
        repeat (2) q.push_back(8'($urandom));
        for (int i = 7; i >= 0; i--) q.push_back(addrs[i*8 +: 8]);
        if (ver_ihl[3:0] > 4'd5)
            repeat ((ver_ihl[3:0] - 5) * 4) q.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--) q.push_back(ports[i*8 +: 8]);
        // rest of the l4 header after the two ports
        repeat ((proto == PROTO_TCP) ? 16 : 4) q.push_back(8'($urandom));
        repeat (payload) q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic push_beat(logic [1:0] cmd, logic [S_TDATA_W-1:0] data, logic last);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (cmd != CMD_RESERVED)
            beats_sent++;
    endtask

    task automatic write_flow(logic [3:0] idx, logic [63:0] addrs, logic [31:0] ports,
            logic valid);
        tbl_addrs[idx] = addrs;
        tbl_ports[idx] = ports;
        tbl_live[idx]  = valid;
        push_beat(CMD_FLOW_WRITE, pack_fields(8'($urandom), 6'($urandom), idx, addrs[63:32],
                  ports[31:16], addrs[31:0], ports[15:0], valid), 1'($urandom));
    endtask

    task automatic bind_socket(logic [5:0] queue, logic bound);
        push_beat(CMD_SOCKET_SET, pack_fields(8'($urandom), queue, 4'($urandom), $urandom,
                  16'($urandom), $urandom, 16'($urandom), bound), 1'($urandom));
    endtask

    task automatic table_command();
        logic [3:0] idx;
        idx = 4'($urandom);
        case ($urandom_range(0, 3))
            0: write_flow(idx, tbl_addrs[idx], tbl_ports[idx],
                          tbl_live[idx] ^ ($urandom_range(0, 4) == 0));
            1: bind_socket(6'($urandom), 1'($urandom));
            2: write_flow(idx, {$urandom, $urandom}, $urandom, $urandom_range(0, 9) != 0);
            default: push_beat(CMD_RESERVED, noisy_fields(8'($urandom), 6'($urandom)),
                               1'($urandom));
        endcase
    endtask

    // table commands may slip in between frame bytes
    task automatic send_frame(byte_q_t q, logic [5:0] queue, int mix_pct);
        for (int i = 0; i < q.size(); i++) begin
            if ($urandom_range(0, 99) < mix_pct)
                table_command();
            push_beat(CMD_BYTE, noisy_fields(q[i], (i == q.size() - 1) ? queue : 6'($urandom)),
                      i == q.size() - 1);
        end
        frames_sent++;
    endtask

    task automatic wait_verdicts();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_frame();
        byte_q_t     q;
        logic [63:0] addrs;
        logic [31:0] ports;
        logic [15:0] etype;
        logic [7:0]  ver_ihl;
        logic [7:0]  proto;
        int          k;
        int          pick;
        int          payload;
        int          need;
        int          cut;
        if ($urandom_range(0, 99) < 70) begin
            pick  = $urandom_range(0, FLOW_ENTRIES - 1);
            addrs = tbl_addrs[pick];
            ports = tbl_ports[pick];
            if ($urandom_range(0, 9) == 0)
                addrs = addrs ^ (64'd1 << $urandom_range(0, 63));
            if ($urandom_range(0, 9) == 0)
                ports = ports ^ (32'd1 << $urandom_range(0, 31));
        end else begin
            addrs = {$urandom, $urandom};
            ports = $urandom;
        end
        etype = ($urandom_range(0, 99) < 92) ? ETYPE_IPV4 : 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 85)
            ver_ihl = 8'h45;
        else if (k < 93)
            ver_ihl = {4'($urandom), 4'($urandom_range(6, 15))};
        else
            ver_ihl = {4'($urandom), 4'($urandom_range(0, 4))};
        k = $urandom_range(0, 99);
        proto = (k < 45) ? PROTO_TCP : (k < 90) ? PROTO_UDP : 8'($urandom);
        k = $urandom_range(0, 99);
        payload = (k < 80) ? $urandom_range(0, 8) :
                  (k < 98) ? $urandom_range(9, 40) : $urandom_range(220, 260);
        q = build_frame(etype, ver_ihl, proto, addrs, ports, payload);
        if ($urandom_range(0, 99) < 15) begin
            need = 14 + ver_ihl[3:0] * 4 + ((proto == PROTO_TCP) ? 20 : 8);
            case ($urandom_range(0, 5))
                0: cut = 13;
                1: cut = 14;
                2: cut = 33;
                3: cut = 34;
                4: cut = need - 1;
                default: cut = $urandom_range(1, q.size());
            endcase
            while (q.size() > cut) void'(q.pop_back());
        end
        send_frame(q, 6'($urandom), 3);
    endtask

    initial begin
        byte_q_t     q;
        logic [63:0] web_addrs;
        logic [31:0] web_ports;
        int          k;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = CMD_BYTE;
        foreach (tbl_live[i]) begin
            tbl_live[i]  = 1'b0;
            tbl_addrs[i] = '0;
            tbl_ports[i] = '0;
        end
        web_addrs = {32'hc0a80101, 32'h0a000002};
        web_ports = {16'd443, 16'd51000};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        bind_socket(6'd63, 1'b1);
        bind_socket(6'd0, 1'b1);
        write_flow(4'd0, '1, '1, 1'b1);
        write_flow(4'd15, '0, '0, 1'b1);
        write_flow(4'd3, web_addrs, web_ports, 1'b1);

        q = build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, '1, '1, 0);
        send_frame(q[0:0], 6'd0, 0);
        send_frame(q[0:12], 6'd63, 0);
        send_frame(q, 6'd63, 0);
        send_frame(q[0:40], 6'd63, 0);
        q = build_frame(16'h86dd, 8'h45, PROTO_UDP, '1, '1, 0);
        send_frame(q, 6'd63, 0);
        // wrong ethertype wins over a short frame
        send_frame(q[0:19], 6'd63, 0);
        q = build_frame(ETYPE_IPV4, 8'h45, PROTO_TCP, web_addrs, web_ports, 4);
        send_frame(q[0:24], 6'd5, 0);
        send_frame(q[0:52], 6'd5, 0);
        send_frame(q, 6'd5, 0);
        bind_socket(6'd5, 1'b1);
        send_frame(q, 6'd5, 25);
        send_frame(build_frame(ETYPE_IPV4, 8'h44, PROTO_TCP, web_addrs, web_ports, 0), 6'd5, 0);
        send_frame(build_frame(ETYPE_IPV4, 8'h45, 8'd1, web_addrs, web_ports, 0), 6'd5, 0);
        // version nibble is ignored, widest ip header
        send_frame(build_frame(ETYPE_IPV4, 8'h6f, PROTO_TCP, '0, '0, 3), 6'd0, 0);
        send_frame(build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, {$urandom, $urandom}, $urandom, 2),
                   6'd0, 0);
        push_beat(CMD_RESERVED, noisy_fields(8'hff, 6'd63), 1'b1);
        write_flow(4'd3, web_addrs, web_ports, 1'b0);
        send_frame(q, 6'd5, 0);
        bind_socket(6'd63, 1'b0);
        send_frame(build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, '1, '1, 0), 6'd63, 0);
        // long frame runs the byte counter into saturation
        send_frame(build_frame(ETYPE_IPV4, 8'h45, PROTO_UDP, '0, '0, 250), 6'd0, 0);

        for (int i = 0; i < FLOW_ENTRIES; i++)
            write_flow(4'(i), {$urandom, $urandom}, $urandom, $urandom_range(0, 9) != 0);
        for (int i = 0; i < QUEUE_COUNT; i++)
            bind_socket(6'(i), $urandom_range(0, 9) < 6);

        frames_sent = 0;
        while (beats_sent < ITEM_TARGET || frames_sent < FRAME_TARGET) begin
            if (frames_sent == 1)
                hold_armed = 1'b1;
            if (frames_sent == 3)
                wait_verdicts();
            calm = (frames_sent >= 4 && frames_sent < 7);
            k = $urandom_range(0, 99);
            if (k < 8)
                write_flow(4'($urandom), {$urandom, $urandom}, $urandom,
                           $urandom_range(0, 99) < 85);
            else if (k < 16)
                bind_socket(6'($urandom), 1'($urandom));
            else if (k < 18)
                push_beat(CMD_RESERVED, noisy_fields(8'($urandom), 6'($urandom)), 1'($urandom));
            random_frame();
        end
        calm = 1'b0;

        wait_verdicts();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("ipv4_flow_tuple_redirect_classifier test passed");
        end else begin
            $display("ipv4_flow_tuple_redirect_classifier test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/iftrc_pkg.sv
rtl/iftrc_flow_table.sv
rtl/ipv4_flow_tuple_redirect_classifier.sv
sim/tb.sv
